// ===== src/brbf_pkg.sv =====
// ============================================================================
// brbf_pkg
// shared types, constants and helpers of the row box blur with fade
// ============================================================================
package brbf_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_W     = 20;
    localparam int MAX_DIM   = 4096;

    localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [PIX_W-1:0] ALPHA_CLEAR  = 8'h00;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_START = 2'd2;

    localparam logic [CFG_W-1:0] RST_ROW_LENGTH = 13'd128;
    localparam logic [CFG_W-1:0] RST_ROW_COUNT  = 13'd96;
    localparam logic [CFG_W-1:0] RST_FADE_START = 13'd96;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0]   red_out;
        logic [PIX_W-1:0]   green_out;
        logic [PIX_W-1:0]   blue_out;
        logic [PIX_W-1:0]   alpha_out;
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
        logic               last_of_run;
    } t_pix_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PAD,
        ST_SUM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic shift_dup;
        logic pad_dec;
        logic alpha_take;
        logic sum_load;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_div;
        logic emit_now;
        logic div_busy;
        logic pad_zero;
        logic emits_zero;
        logic emit_last;
        logic out_free;
    } t_dp_stat;

    // zero acts as one, oversized values clamp to the largest dimension
    function automatic logic [CFG_W-1:0] dim_eff(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > CFG_W'(MAX_DIM)) begin
            r = CFG_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== src/brbf_div.sv =====
// ============================================================================
// brbf_div
// restoring divider for the row alpha, one quotient bit per cycle
// ============================================================================
module brbf_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [brbf_pkg::NUM_W-1:0]          i_num,
    input  logic [brbf_pkg::COORD_W-1:0]        i_den,
    output logic                                o_busy,
    output logic [brbf_pkg::PIX_W-1:0]          o_quot
);

    logic                              r_busy;
    logic [2:0]                        r_step;
    logic [brbf_pkg::COORD_W-1:0]      r_rem;
    logic [brbf_pkg::COORD_W-1:0]      r_den;
    logic [brbf_pkg::PIX_W-1:0]        r_lo;
    logic [brbf_pkg::COORD_W:0]        trial;
    logic                              ge;

    // quotient fits in eight bits, so the upper dividend bits seed the remainder
    assign trial = {r_rem, r_lo[brbf_pkg::PIX_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 3'd1;
            if (r_step == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[brbf_pkg::NUM_W-1 -: brbf_pkg::COORD_W];
            r_lo  <= i_num[brbf_pkg::PIX_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? brbf_pkg::COORD_W'(trial - {1'b0, r_den})
                        : trial[brbf_pkg::COORD_W-1:0];
            r_lo  <= {r_lo[brbf_pkg::PIX_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_lo;

endmodule

// ===== src/brbf_ctrl.sv =====
// ============================================================================
// brbf_ctrl
// sequencer: accept, alpha divide, edge padding, sum and result issue
// ============================================================================
module brbf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  brbf_pkg::t_dp_stat   i_stat,
    output brbf_pkg::t_ctrl_cmd  o_cmd,
    output logic                 o_ready
);

    brbf_pkg::t_state r_state;
    brbf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brbf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            brbf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.need_div) begin
                        n_state = brbf_pkg::ST_DIV;
                    end else if (i_stat.emit_now) begin
                        n_state = brbf_pkg::ST_PAD;
                    end
                end
            end
            brbf_pkg::ST_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = i_stat.emits_zero ? brbf_pkg::ST_IDLE : brbf_pkg::ST_PAD;
                end
            end
            brbf_pkg::ST_PAD: begin
                if (i_stat.pad_zero) begin
                    n_state = brbf_pkg::ST_SUM;
                end
            end
            brbf_pkg::ST_SUM: begin
                n_state = brbf_pkg::ST_OUT;
            end
            brbf_pkg::ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.emit_last ? brbf_pkg::ST_IDLE : brbf_pkg::ST_SUM;
                end
            end
            default: begin
                n_state = brbf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            brbf_pkg::ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            brbf_pkg::ST_DIV: begin
                o_cmd.alpha_take = !i_stat.div_busy;
            end
            brbf_pkg::ST_PAD: begin
                o_cmd.shift_dup = !i_stat.pad_zero;
                o_cmd.pad_dec   = !i_stat.pad_zero;
            end
            brbf_pkg::ST_SUM: begin
                o_cmd.sum_load = 1'b1;
            end
            brbf_pkg::ST_OUT: begin
                o_cmd.out_load  = i_stat.out_free;
                // next window position while this result goes out
                o_cmd.shift_dup = i_stat.out_free && !i_stat.emit_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/brbf_dp.sv =====
// ============================================================================
// brbf_dp
// datapath: config registers, pixel window, counters, sums and output register
// ============================================================================
module brbf_dp #(
    parameter int BLUR_RADIUS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  brbf_pkg::t_pix_in                   i_pix,
    input  logic                                i_cfg_we,
    input  logic [brbf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [brbf_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_out_stall,
    input  brbf_pkg::t_ctrl_cmd                 i_cmd,
    output brbf_pkg::t_dp_stat                  o_stat,
    output logic                                o_out_valid,
    output brbf_pkg::t_pix_out                  o_out_data
);

    localparam int TAPS   = 2 * BLUR_RADIUS + 1;
    localparam int SUM_W  = brbf_pkg::PIX_W + $clog2(TAPS);
    localparam int CNT_W  = $clog2(BLUR_RADIUS + 2);
    localparam int DIV_SH = SUM_W + $clog2(TAPS);
    localparam int M_W    = DIV_SH - $clog2(TAPS) + 2;
    localparam int P_W    = SUM_W + M_W;
    localparam logic [M_W-1:0] DIV_M = M_W'(((1 << DIV_SH) + TAPS - 1) / TAPS);
    localparam logic [brbf_pkg::COORD_W-1:0] RAD = brbf_pkg::COORD_W'(BLUR_RADIUS);

    // config
    logic [brbf_pkg::CFG_W-1:0] r_row_length;
    logic [brbf_pkg::CFG_W-1:0] r_row_count;
    logic [brbf_pkg::CFG_W-1:0] r_fade_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= brbf_pkg::RST_ROW_LENGTH;
            r_row_count  <= brbf_pkg::RST_ROW_COUNT;
            r_fade_start <= brbf_pkg::RST_FADE_START;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                brbf_pkg::CFG_ROW_LENGTH: r_row_length <= i_cfg_data;
                brbf_pkg::CFG_ROW_COUNT:  r_row_count  <= i_cfg_data;
                brbf_pkg::CFG_FADE_START: r_fade_start <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // position and row decode
    logic [brbf_pkg::COORD_W-1:0] r_col;
    logic [brbf_pkg::COORD_W-1:0] r_row;
    logic [brbf_pkg::CFG_W-1:0]   len_eff;
    logic [brbf_pkg::CFG_W-1:0]   cnt_eff;
    logic [brbf_pkg::COORD_W-1:0] h1;
    logic [brbf_pkg::COORD_W-1:0] rows_left;
    logic [brbf_pkg::COORD_W-1:0] fade_den;
    logic [brbf_pkg::NUM_W-1:0]   fade_num;
    logic                         col0;
    logic                         is_last;
    logic                         past_rad;
    logic                         fade_off;
    logic                         fade_zero;

    assign len_eff   = brbf_pkg::dim_eff(r_row_length);
    assign cnt_eff   = brbf_pkg::dim_eff(r_row_count);
    assign h1        = brbf_pkg::COORD_W'(cnt_eff - 13'd1);
    assign col0      = r_col == '0;
    assign is_last   = ({1'b0, r_col} + 13'd1) >= len_eff;
    assign past_rad  = r_col >= RAD;
    assign fade_off  = ({1'b0, r_row} < r_fade_start) || ({1'b0, h1} <= r_fade_start);
    assign fade_zero = r_row >= h1;
    assign rows_left = h1 - r_row;
    assign fade_den  = h1 - r_fade_start[brbf_pkg::COORD_W-1:0];
    // rows_left * 255
    assign fade_num  = ({rows_left, 8'd0}) - {8'd0, rows_left};

    logic                       div_busy;
    logic [brbf_pkg::PIX_W-1:0] div_quot;
    logic                       div_start;

    assign div_start = i_cmd.accept && col0 && !fade_off && !fade_zero;

    brbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (fade_num),
        .i_den   (fade_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // counters and run bookkeeping
    logic [brbf_pkg::COORD_W-1:0] r_emit_col;
    logic [brbf_pkg::COORD_W-1:0] r_emit_row;
    logic [CNT_W-1:0]             r_pad;
    logic [CNT_W-1:0]             r_emits;
    logic [brbf_pkg::PIX_W-1:0]   r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_pad   <= '0;
            r_emits <= '0;
            r_alpha <= brbf_pkg::ALPHA_OPAQUE;
        end else begin
            if (i_cmd.accept) begin
                if (is_last) begin
                    r_col <= '0;
                    if (({1'b0, r_row} + 13'd1) >= cnt_eff) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + 12'd1;
                    end
                    r_pad   <= past_rad ? '0 : CNT_W'(RAD - r_col);
                    r_emits <= past_rad ? CNT_W'(BLUR_RADIUS + 1) : CNT_W'(r_col + 12'd1);
                end else begin
                    r_col   <= r_col + 12'd1;
                    r_pad   <= '0;
                    r_emits <= past_rad ? CNT_W'(1) : '0;
                end
                if (col0 && fade_off) begin
                    r_alpha <= brbf_pkg::ALPHA_OPAQUE;
                end else if (col0 && fade_zero) begin
                    r_alpha <= brbf_pkg::ALPHA_CLEAR;
                end
            end else begin
                if (i_cmd.pad_dec) begin
                    r_pad <= r_pad - CNT_W'(1);
                end
                if (i_cmd.out_load) begin
                    r_emits <= r_emits - CNT_W'(1);
                end
                if (i_cmd.alpha_take) begin
                    r_alpha <= div_quot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_emit_col <= past_rad ? r_col - RAD : '0;
            r_emit_row <= r_row;
        end else if (i_cmd.out_load) begin
            r_emit_col <= r_emit_col + 12'd1;
        end
    end

    // pixel window: newest at tap 0, row start fills every tap with the edge pixel
    brbf_pkg::t_pix_in r_win [TAPS];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TAPS; i++) begin
            if (i_cmd.accept && col0) begin
                r_win[i] <= i_pix;
            end else if (i_cmd.accept || i_cmd.shift_dup) begin
                if (i == 0) begin
                    r_win[i] <= i_cmd.accept ? i_pix : r_win[0];
                end else begin
                    r_win[i] <= r_win[i-1];
                end
            end
        end
    end

    // window sums
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    logic [SUM_W-1:0] r_sum_r;
    logic [SUM_W-1:0] r_sum_g;
    logic [SUM_W-1:0] r_sum_b;

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < TAPS; i++) begin
            sum_r = sum_r + SUM_W'(r_win[i].red_in);
            sum_g = sum_g + SUM_W'(r_win[i].green_in);
            sum_b = sum_b + SUM_W'(r_win[i].blue_in);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_load) begin
            r_sum_r <= sum_r;
            r_sum_g <= sum_g;
            r_sum_b <= sum_b;
        end
    end

    // divide by tap count: exact reciprocal multiply
    logic [P_W-1:0] prod_r;
    logic [P_W-1:0] prod_g;
    logic [P_W-1:0] prod_b;

    assign prod_r = P_W'(r_sum_r) * P_W'(DIV_M);
    assign prod_g = P_W'(r_sum_g) * P_W'(DIV_M);
    assign prod_b = P_W'(r_sum_b) * P_W'(DIV_M);

    // output register
    logic                r_out_valid;
    brbf_pkg::t_pix_out  r_out;
    logic                out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.red_out     <= prod_r[DIV_SH +: brbf_pkg::PIX_W];
            r_out.green_out   <= prod_g[DIV_SH +: brbf_pkg::PIX_W];
            r_out.blue_out    <= prod_b[DIV_SH +: brbf_pkg::PIX_W];
            r_out.alpha_out   <= r_alpha;
            r_out.out_column  <= r_emit_col;
            r_out.out_row     <= r_emit_row;
            r_out.last_of_run <= r_emits == CNT_W'(1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_stat            = '0;
        o_stat.need_div   = col0 && !fade_off && !fade_zero;
        o_stat.emit_now   = is_last || past_rad;
        o_stat.div_busy   = div_busy;
        o_stat.pad_zero   = r_pad == '0;
        o_stat.emits_zero = r_emits == '0;
        o_stat.emit_last  = r_emits == CNT_W'(1);
        o_stat.out_free   = out_free;
    end

endmodule

// ===== src/box_row_blur_fade_unit.sv =====
// ============================================================================
// box_row_blur_fade_unit
// horizontal box blur pass with per-row fade alpha, transposed addressing
// ============================================================================
// one horizontal pass of a separable box blur of radius BLUR_RADIUS over an
// rgb raster that arrives row by row. each result is the truncated average of
// the 2R+1 pixels around its column, edge pixels repeated past either end of
// the row, and carries its column and row so the writer can store it at
// col*row_count+row. results lag the input by R pixels and the last pixel of a
// row flushes the rest of that row. every result of a row carries one alpha,
// opaque before fade_start and ramping down to zero at the last row.
// sequencing: a pixel that produces no result leaves the sequencer idle, so
// the next one is taken on the following clock. a pixel that produces one
// result holds the input side through accept, window check, sum and result
// load, and the pixel ending a row holds it for a sum and a result load for
// each of its n results (n = R+1 on rows of at least R+1 pixels) plus a
// padding step per padded tap on rows shorter than R+1. the first pixel of a
// row in the fading band also waits for the bit-serial alpha divider. a held
// result on the output side only stalls the block when the next result is due
// ============================================================================
module box_row_blur_fade_unit #(
    parameter int BLUR_RADIUS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    // pixel input
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  brbf_pkg::t_pix_in                  i_in_data,

    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output brbf_pkg::t_pix_out                 o_out_data,

    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [brbf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [brbf_pkg::CFG_W-1:0]         i_cfg_data
);

    brbf_pkg::t_ctrl_cmd cmd;
    brbf_pkg::t_dp_stat  stat;
    logic                ready;

    // config must only be written while idle (the block does not enforce it), so every transfer is taken at once
    assign o_cfg_ready = 1'b1;

    // input side takes a transfer only when the sequencer is back at idle
    assign o_in_stall = !ready;

    brbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_ready    (ready)
    );

    // window, counters, alpha divider and the output register
    brbf_dp #(
        .BLUR_RADIUS (BLUR_RADIUS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/brbf_checker.sv =====
// ============================================================================
// brbf_checker
// port-level checks of the row box blur with fade
// ============================================================================
module brbf_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  brbf_pkg::t_pix_out  o_out_data
);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // while a run of results is not finished, no new pixel is taken
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_of_run |-> o_in_stall)
        else $error("pixel taken in the middle of a result run");

endmodule

bind box_row_blur_fade_unit brbf_checker u_brbf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
